// ===== src/apr_pkg.sv =====
// ----------------------------------------------------------------------------
// apr_pkg
// Types, constants and helpers shared by the power register block.
// ----------------------------------------------------------------------------
package apr_pkg;

  // Register file geometry.
  localparam int unsigned REG_FILE_BYTES = 224;
  localparam int unsigned IDX_W          = $clog2(REG_FILE_BYTES);
  localparam int unsigned ADDR_W         = 8;
  localparam logic [ADDR_W:0] FILE_END   = (ADDR_W + 1)'(REG_FILE_BYTES);

  // Bus offsets are given relative to the start of the file.
  localparam logic [ADDR_W-1:0] FILE_BASE = 8'h20;
  localparam logic [ADDR_W-1:0] CTL_IDX   = 8'h2a - FILE_BASE;
  localparam logic [ADDR_W-1:0] REL_IDX   = 8'h2c - FILE_BASE;
  localparam logic [ADDR_W-1:0] SMI_IDX   = 8'h2f - FILE_BASE;

  // Bits of interest.
  localparam int unsigned CTL_SMI_CTRL_BIT = 5;
  localparam int unsigned CTL_SMI_FILE_BIT = 6;
  localparam int unsigned SLP_EN_BIT       = 13;
  localparam int unsigned CTRL_SMI_BIT     = 1;

  typedef enum logic [1:0] {
    CMD_FILE_RD = 2'd0,
    CMD_FILE_WR = 2'd1,
    CMD_CTRL_RD = 2'd2,
    CMD_CTRL_WR = 2'd3
  } apr_cmd_e;

  typedef enum logic [2:0] {
    SLP_TYP_SUSPEND = 3'd1,
    SLP_TYP_DISK    = 3'd2
  } apr_slp_typ_e;

  typedef struct packed {
    logic [1:0]        command;
    logic [ADDR_W-1:0] address;
    logic [15:0]       write_data;
  } apr_in_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic        smi_raise;
    logic        sci_raise;
    logic        release_status_set;
    logic        suspend_request;
    logic        disk_shutdown_request;
  } apr_out_t;

  // Register file write port.
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic [7:0]       data;
  } apr_file_wr_t;

  // PM1 control register update.
  typedef struct packed {
    logic        en;
    logic [15:0] value;
  } apr_ctrl_wr_t;

  // File indexes whose bytes the bus cannot change.
  function automatic logic is_read_only(logic [ADDR_W-1:0] idx);
    logic ro;
    case (idx + FILE_BASE) inside
      8'h28, 8'h29, [8'h30:8'h33], 8'h40, 8'h45: ro = 1'b1;
      default:                                  ro = 1'b0;
    endcase
    return ro;
  endfunction

endpackage

// ===== src/acpi_power_register_block_unit.sv =====
// ----------------------------------------------------------------------------
// acpi_power_register_block_unit
// Power-management register file and PM1 control register behind one
// request channel and one response channel.
// ----------------------------------------------------------------------------
// Every request transaction (read or write of the register file or of the
// PM1 control register) yields exactly one response transaction, in order.
// Both channels use valid and stall; a transaction moves at a rising edge
// with valid high and stall low.
// A request waits in the input stage, where the register file read port is
// registered; the response register is loaded from it when the stage advances.
// Throughput: one transaction per cycle while the receiver does not stall;
// the single-port file write commits as the input stage hands its result to
// the response register, and a read of the next request forwards that byte.
// When the receiver stalls, the response register holds; the input stage
// still takes one more request, and only then is the request channel stalled.
// Reset clears the control register, the pipeline valid flags and the per
// entry valid bits of the register file, so the whole file reads as zero at
// once and no clearing pass is needed.
// ----------------------------------------------------------------------------
module acpi_power_register_block_unit import apr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  apr_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output apr_out_t out_data_o
);

  apr_in_t      s1_q;
  logic         s1_valid_q;
  apr_out_t     out_data_q;
  logic         out_valid_q;
  logic [15:0]  pm_control_q;

  logic         out_free;
  logic         s1_adv;
  logic         accept;
  logic [7:0]   file_byte;
  logic [7:0]   ctl_byte;
  apr_out_t     result;
  apr_file_wr_t file_wr;
  apr_file_wr_t file_commit;
  apr_ctrl_wr_t ctrl_wr;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign accept     = in_valid_i && !in_stall_o;

  // State changes only when the item leaves the input stage.
  always_comb begin
    file_commit    = file_wr;
    file_commit.en = file_wr.en && s1_adv;
  end

  apr_reg_file u_reg_file (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (accept),
    .rd_idx_i   (in_data_i.address[IDX_W-1:0]),
    .wr_i       (file_commit),
    .rd_byte_o  (file_byte),
    .ctl_byte_o (ctl_byte)
  );

  apr_exec u_exec (
    .item_i       (s1_q),
    .file_byte_i  (file_byte),
    .ctl_byte_i   (ctl_byte),
    .pm_control_i (pm_control_q),
    .result_o     (result),
    .file_wr_o    (file_wr),
    .ctrl_wr_o    (ctrl_wr)
  );

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= in_data_i;
    end
    if (s1_adv) begin
      out_data_q <= result;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      pm_control_q <= '0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (s1_adv && ctrl_wr.en) begin
        pm_control_q <= ctrl_wr.value;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  a_sci_with_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_data_q.sci_raise == out_data_q.release_status_set))
    else $error("SCI pulse without matching release status");

  a_sleep_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_data_q.suspend_request && out_data_q.disk_shutdown_request))
    else $error("suspend and disk shutdown requested together");

  a_slp_en_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && ctrl_wr.en) |=> !pm_control_q[SLP_EN_BIT])
    else $error("sleep enable kept in the stored control register");

  a_adv_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_valid_q)
    else $error("input stage result lost");
`endif

endmodule

// ===== src/apr_reg_file.sv =====
// ----------------------------------------------------------------------------
// apr_reg_file
// Byte-wide power register file with a registered read port, per-entry
// valid bits that reset clears, write forwarding and a shadow of byte 0x2a.
// ----------------------------------------------------------------------------
module apr_reg_file import apr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [IDX_W-1:0] rd_idx_i,
  input  apr_file_wr_t     wr_i,
  output logic [7:0]       rd_byte_o,
  output logic [7:0]       ctl_byte_o
);

  logic [7:0]                mem [REG_FILE_BYTES];
  logic [REG_FILE_BYTES-1:0] vld_q;
  logic [7:0]                rd_q;
  logic                      rd_vld_q;
  logic                      fwd_q;
  logic [7:0]                fwd_data_q;
  logic [7:0]                ctl_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.idx] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd_q       <= mem[rd_idx_i];
      fwd_data_q <= wr_i.data;
    end
  end

  // The read happens at the same edge as a write of the previous item, so a
  // matching address takes the byte being written.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
      fwd_q    <= 1'b0;
      ctl_q    <= '0;
    end else begin
      if (wr_i.en) begin
        vld_q[wr_i.idx] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_idx_i];
        fwd_q    <= wr_i.en && (wr_i.idx == rd_idx_i);
      end
      if (wr_i.en && (wr_i.idx == CTL_IDX[IDX_W-1:0])) begin
        ctl_q <= wr_i.data;
      end
    end
  end

  assign rd_byte_o  = fwd_q ? fwd_data_q : (rd_vld_q ? rd_q : 8'h00);
  assign ctl_byte_o = ctl_q;

endmodule

// ===== src/apr_exec.sv =====
// ----------------------------------------------------------------------------
// apr_exec
// Decodes one bus transaction and forms its result, the register file write
// and the PM1 control update.
// ----------------------------------------------------------------------------
module apr_exec import apr_pkg::*; (
  input  apr_in_t      item_i,
  input  logic [7:0]   file_byte_i,
  input  logic [7:0]   ctl_byte_i,
  input  logic [15:0]  pm_control_i,
  output apr_out_t     result_o,
  output apr_file_wr_t file_wr_o,
  output apr_ctrl_wr_t ctrl_wr_o
);

  logic        in_range;
  logic [15:0] ctrl_val;
  logic [2:0]  slp_typ;

  assign in_range = {1'b0, item_i.address} < FILE_END;
  assign ctrl_val = (item_i.address == 8'd1) ? {item_i.write_data[7:0], pm_control_i[7:0]}
                                             : item_i.write_data;
  assign slp_typ  = ctrl_val[12:10];

  always_comb begin
    result_o       = '0;
    file_wr_o.en   = 1'b0;
    file_wr_o.idx  = item_i.address[IDX_W-1:0];
    file_wr_o.data = item_i.write_data[7:0];
    ctrl_wr_o.en   = 1'b0;
    ctrl_wr_o.value = ctrl_val;
    ctrl_wr_o.value[SLP_EN_BIT] = 1'b0;
    case (item_i.command)
      CMD_FILE_RD: begin
        if (in_range) begin
          result_o.read_data = {8'h00, file_byte_i};
        end
      end
      CMD_FILE_WR: begin
        if (in_range && !is_read_only(item_i.address)) begin
          file_wr_o.en = 1'b1;
          if (item_i.address == REL_IDX) begin
            result_o.sci_raise          = item_i.write_data[0];
            result_o.release_status_set = item_i.write_data[0];
          end else if (item_i.address == SMI_IDX) begin
            result_o.smi_raise = ctl_byte_i[CTL_SMI_FILE_BIT];
          end
        end
      end
      CMD_CTRL_RD: begin
        if (item_i.address == 8'd0) begin
          result_o.read_data = pm_control_i;
        end else if (item_i.address == 8'd1) begin
          result_o.read_data = {8'h00, pm_control_i[15:8]};
        end
      end
      CMD_CTRL_WR: begin
        ctrl_wr_o.en = 1'b1;
        result_o.smi_raise = item_i.write_data[CTRL_SMI_BIT] && ctl_byte_i[CTL_SMI_CTRL_BIT];
        if (ctrl_val[SLP_EN_BIT]) begin
          result_o.suspend_request       = (slp_typ == SLP_TYP_SUSPEND);
          result_o.disk_shutdown_request = (slp_typ == SLP_TYP_DISK);
        end
      end
      default: begin
        result_o = '0;
      end
    endcase
  end

endmodule

// ===== sim/acpi_power_register_block_unit_test.sv =====
// ----------------------------------------------------------------------------
// acpi_power_register_block_unit_test
// Self-checking bench for the power register block. A queue-fed driver
// offers bus accesses, a shadow copy of the register file and the PM1
// control register predicts each response, and a monitor compares every
// response transaction field by field, in order, under random stalls.
// ----------------------------------------------------------------------------
module acpi_power_register_block_unit_test;
  import apr_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1500;
  localparam int unsigned HOLD_CYCLES  = 120;
  localparam int unsigned IDLE_PERCENT = 6;
  localparam int unsigned DRAIN_CYCLES = 10;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_stall_o;
  apr_in_t  in_data_i   = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  apr_out_t out_data_o;

  apr_in_t  pending_q[$];
  apr_out_t response_q[$];

  logic [7:0]  shadow_file [REG_FILE_BYTES];
  logic [15:0] shadow_ctrl;

  int unsigned error_count    = 0;
  logic        sender_paused  = 1'b0;
  logic        steady_run     = 1'b0;
  int unsigned hold_req_count = 0;
  int unsigned hold_ack_count = 0;
  int unsigned hold_left      = 0;

  acpi_power_register_block_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic logic file_locked(logic [ADDR_W-1:0] idx);
    case ({1'b0, idx} + 9'h020)
      9'h028, 9'h029, 9'h030, 9'h031, 9'h032, 9'h033, 9'h040, 9'h045: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // Applies one access to the shadow state and returns the response it causes.
  function automatic apr_out_t predict_access(apr_in_t acc);
    apr_out_t    res;
    logic [15:0] merged;
    res = '0;
    case (apr_cmd_e'(acc.command))
      CMD_FILE_RD: begin
        if (acc.address < REG_FILE_BYTES) res.read_data = {8'h00, shadow_file[acc.address]};
      end
      CMD_FILE_WR: begin
        if (acc.address < REG_FILE_BYTES && !file_locked(acc.address)) begin
          shadow_file[acc.address] = acc.write_data[7:0];
          if (acc.address == REL_IDX && shadow_file[REL_IDX][0]) begin
            res.sci_raise          = 1'b1;
            res.release_status_set = 1'b1;
          end else if (acc.address == SMI_IDX && shadow_file[CTL_IDX][CTL_SMI_FILE_BIT]) begin
            res.smi_raise = 1'b1;
          end
        end
      end
      CMD_CTRL_RD: begin
        if (acc.address == 8'd0) res.read_data = shadow_ctrl;
        else if (acc.address == 8'd1) res.read_data = {8'h00, shadow_ctrl[15:8]};
      end
      default: begin
        res.smi_raise = acc.write_data[CTRL_SMI_BIT] && shadow_file[CTL_IDX][CTL_SMI_CTRL_BIT];
        // The high byte write keeps the current low byte underneath.
        merged = (acc.address == 8'd1) ? {acc.write_data[7:0], shadow_ctrl[7:0]}
                                       : acc.write_data;
        shadow_ctrl = merged;
        shadow_ctrl[SLP_EN_BIT] = 1'b0;
        if (merged[SLP_EN_BIT]) begin
          if (merged[12:10] == SLP_TYP_SUSPEND) res.suspend_request = 1'b1;
          else if (merged[12:10] == SLP_TYP_DISK) res.disk_shutdown_request = 1'b1;
        end
      end
    endcase
    return res;
  endfunction

  function automatic apr_in_t random_access();
    apr_in_t     acc;
    int unsigned pick;
    acc.command    = 2'($urandom_range(3));
    acc.write_data = 16'($urandom);
    pick           = $urandom_range(99);
    if (acc.command == CMD_CTRL_RD || acc.command == CMD_CTRL_WR) begin
      acc.address = (pick < 85) ? 8'($urandom_range(1)) : 8'($urandom_range(255));
    end else if (pick < 45) begin
      // Most file traffic lands on the low bytes where the side effects live.
      acc.address = 8'($urandom_range(8'h2f));
    end else if (pick < 90) begin
      acc.address = 8'($urandom_range(REG_FILE_BYTES - 1));
    end else begin
      acc.address = 8'($urandom_range(255, REG_FILE_BYTES));
    end
    return acc;
  endfunction

  task automatic queue_access(apr_cmd_e cmd, logic [7:0] addr, logic [15:0] data);
    apr_in_t acc;
    acc.command    = cmd;
    acc.address    = addr;
    acc.write_data = data;
    pending_q.push_back(acc);
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_q.size() != 0 || in_valid_i || response_q.size() != 0);
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk_i) begin : drive_proc
    logic    nxt_valid;
    apr_in_t nxt_data;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
    end else begin
      nxt_valid = in_valid_i;
      nxt_data  = in_data_i;
      if (in_valid_i && !in_stall_o) begin
        response_q.push_back(predict_access(in_data_i));
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && pending_q.size() != 0 && !sender_paused &&
          (steady_run || $urandom_range(99) >= IDLE_PERCENT)) begin
        nxt_valid = 1'b1;
        nxt_data  = pending_q.pop_front();
      end
      in_valid_i <= nxt_valid;
      in_data_i  <= nxt_data;
    end
  end

  always @(posedge clk_i) begin : receive_proc
    apr_out_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (response_q.size() == 0) begin
          $display("%0t: response transaction with none expected, actual %p", $time, out_data_o);
          error_count++;
        end else begin
          want = response_q.pop_front();
          check_field("read_data", want.read_data, out_data_o.read_data);
          check_field("smi_raise", want.smi_raise, out_data_o.smi_raise);
          check_field("sci_raise", want.sci_raise, out_data_o.sci_raise);
          check_field("release_status_set", want.release_status_set,
                      out_data_o.release_status_set);
          check_field("suspend_request", want.suspend_request, out_data_o.suspend_request);
          check_field("disk_shutdown_request", want.disk_shutdown_request,
                      out_data_o.disk_shutdown_request);
        end
      end
      if (hold_ack_count != hold_req_count) begin
        hold_ack_count = hold_req_count;
        hold_left      = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !steady_run && ($urandom_range(99) < IDLE_PERCENT);
      end
    end
  end

  initial begin
    #800000;
    $display("FAIL");
    $finish;
  end

  initial begin
    foreach (shadow_file[i]) shadow_file[i] = 8'h00;
    shadow_ctrl = 16'h0000;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed accesses: interrupt triggers, locked bytes, range edges, sleep.
    queue_access(CMD_FILE_WR, CTL_IDX, 16'h0060);
    queue_access(CMD_FILE_WR, SMI_IDX, 16'h00ff);
    queue_access(CMD_FILE_WR, REL_IDX, 16'h0001);
    queue_access(CMD_FILE_WR, REL_IDX, 16'hfffe);
    queue_access(CMD_FILE_RD, REL_IDX, 16'hffff);
    queue_access(CMD_FILE_WR, 8'h08, 16'h00ff);
    queue_access(CMD_FILE_RD, 8'h08, 16'h0000);
    queue_access(CMD_FILE_WR, 8'h25, 16'h00aa);
    queue_access(CMD_FILE_RD, 8'h25, 16'h0000);
    queue_access(CMD_FILE_WR, 8'hdf, 16'hffa5);
    queue_access(CMD_FILE_RD, 8'hdf, 16'h0000);
    queue_access(CMD_FILE_WR, 8'he0, 16'h0077);
    queue_access(CMD_FILE_RD, 8'hff, 16'h0000);
    queue_access(CMD_CTRL_WR, 8'h00, 16'h2402);
    queue_access(CMD_CTRL_RD, 8'h00, 16'h0000);
    queue_access(CMD_CTRL_WR, 8'h01, 16'h0028);
    queue_access(CMD_CTRL_RD, 8'h01, 16'h0000);
    queue_access(CMD_CTRL_WR, 8'h00, 16'hffff);
    queue_access(CMD_CTRL_RD, 8'h00, 16'h0000);
    queue_access(CMD_CTRL_RD, 8'h02, 16'h0000);
    queue_access(CMD_FILE_WR, CTL_IDX, 16'h0000);
    queue_access(CMD_FILE_WR, SMI_IDX, 16'h0012);
    queue_access(CMD_CTRL_WR, 8'hff, 16'h0002);
    queue_access(CMD_CTRL_RD, 8'hff, 16'h0000);
    wait_drained();

    // Hold the response side long enough that the request side backs up.
    hold_req_count++;
    repeat (40) pending_q.push_back(random_access());
    wait_drained();

    repeat (RANDOM_ITEMS / 3) pending_q.push_back(random_access());
    wait_drained();

    steady_run = 1'b1;
    repeat (RANDOM_ITEMS / 3) pending_q.push_back(random_access());
    wait_drained();
    steady_run = 1'b0;

    // The sender sits out a while before the last stretch.
    sender_paused = 1'b1;
    repeat (20) @(negedge clk_i);
    sender_paused = 1'b0;
    repeat (RANDOM_ITEMS / 3) pending_q.push_back(random_access());
    wait_drained();

    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
